[hdl/ddpd_pkg.sv]
`timescale 1ns / 1ps
// ddpd_pkg: shared types and constants for the differential drive pd controller
// holds the item structs and the configuration register indexes; no dependencies

package ddpd_pkg;

  // configuration port widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P_FORWARD = 3'd0,
    CFG_GAIN_P_TURN    = 3'd1,
    CFG_GAIN_D_FORWARD = 3'd2,
    CFG_GAIN_D_TURN    = 3'd3,
    CFG_DRIVE_ENABLE   = 3'd4,
    CFG_HOLD_WHEN_OFF  = 3'd5
  } cfg_idx_t;

  // one control tick worth of input
  typedef struct packed {
    logic [15:0]        left_count;
    logic [15:0]        right_count;
    logic signed [15:0] target_forward;
    logic signed [15:0] target_turn;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic       left_dir;
    logic [9:0] left_compare;
    logic       right_dir;
    logic [9:0] right_compare;
    logic       drive_written;
  } out_item_t;

endpackage

[hdl/differential_drive_pd_controller_core.sv]
`timescale 1ns / 1ps
// differential_drive_pd_controller_core: top level of the pd speed controller
// depends on ddpd_pkg for item types and register indexes

// One item is one control tick: encoder counts and speed targets go in, one
// result with direction bits and pwm compare values comes out. The block is a
// four-stage pipeline (input register, error update, pd multiply, mix and
// map into the output register) and accepts a new item every clock cycle while
// the output is not stalled. An item is registered in turn in the input, error,
// pd and output registers, and its result is shown from the output register.
// The loop through the encoder and error state closes inside the error update
// stage, which is what lets items follow one another without gaps. Bubbles
// are squeezed out when the output is stalled, so up to four items may sit
// in flight. Configuration is a simple write port that is always ready and
// should only be written while no item is in flight.

module differential_drive_pd_controller_core
  import ddpd_pkg::*;
#(
  parameter int PWM_PERIOD = 1000
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input item channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result item channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic signed [16:0] PERIOD_S = 17'(PWM_PERIOD);
  localparam logic signed [16:0] LIM_S    = 17'(PWM_PERIOD - 1);

  // configuration registers
  logic [15:0] gain_p_fwd_r, gain_p_turn_r, gain_d_fwd_r, gain_d_turn_r;
  logic        drive_enable_r, hold_when_off_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_fwd_r    <= 16'd1;
      gain_p_turn_r   <= 16'd1;
      gain_d_fwd_r    <= 16'd1;
      gain_d_turn_r   <= 16'd1;
      drive_enable_r  <= 1'b0;
      hold_when_off_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GAIN_P_FORWARD: gain_p_fwd_r    <= cfg_data;
        CFG_GAIN_P_TURN:    gain_p_turn_r   <= cfg_data;
        CFG_GAIN_D_FORWARD: gain_d_fwd_r    <= cfg_data;
        CFG_GAIN_D_TURN:    gain_d_turn_r   <= cfg_data;
        CFG_DRIVE_ENABLE:   drive_enable_r  <= cfg_data[0];
        CFG_HOLD_WHEN_OFF:  hold_when_off_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline occupancy and flow control
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic out_free, s3_free, s2_free, s1_free;

  assign out_free = !out_v_r || !out_stall;
  assign s3_free  = !s3_v_r || out_free;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_stall = !s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_free)  s1_v_r  <= in_valid;
      if (s2_free)  s2_v_r  <= s1_v_r;
      if (s3_free)  s3_v_r  <= s2_v_r;
      if (out_free) out_v_r <= s3_v_r;
    end
  end

  // input register
  in_item_t s1_r;

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_r <= in_data;
    end
  end

  // error update: wheel speeds, feedback and position error accumulation
  // the last error always equals the position error before this tick
  logic [15:0] prev_left_r, prev_right_r, pos_err_fwd_r, pos_err_turn_r;
  logic [15:0] neg_left, speed_left, speed_right, fb_fwd, fb_turn;
  logic [15:0] pos_err_fwd_nxt, pos_err_turn_nxt;
  logic        s1_move;

  assign s1_move          = s1_v_r && s2_free;
  assign neg_left         = 16'd0 - s1_r.left_count;
  assign speed_left       = neg_left - prev_left_r;
  assign speed_right      = s1_r.right_count - prev_right_r;
  assign fb_fwd           = speed_right + speed_left;
  assign fb_turn          = speed_right - speed_left;
  assign pos_err_fwd_nxt  = pos_err_fwd_r + s1_r.target_forward - fb_fwd;
  assign pos_err_turn_nxt = pos_err_turn_r + s1_r.target_turn - fb_turn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_left_r    <= '0;
      prev_right_r   <= '0;
      pos_err_fwd_r  <= '0;
      pos_err_turn_r <= '0;
    end else if (s1_move) begin
      prev_left_r    <= neg_left;
      prev_right_r   <= s1_r.right_count;
      pos_err_fwd_r  <= pos_err_fwd_nxt;
      pos_err_turn_r <= pos_err_turn_nxt;
    end
  end

  logic [15:0] err_fwd_r, derr_fwd_r, err_turn_r, derr_turn_r;

  always_ff @(posedge clk) begin
    if (s2_free) begin
      err_fwd_r   <= pos_err_fwd_nxt;
      derr_fwd_r  <= pos_err_fwd_nxt - pos_err_fwd_r;
      err_turn_r  <= pos_err_turn_nxt;
      derr_turn_r <= pos_err_turn_nxt - pos_err_turn_r;
    end
  end

  // pd terms, only the low 16 bits of the products are kept
  logic [15:0] p_fwd, d_fwd, p_turn, d_turn;
  logic [15:0] pd_fwd_r, pd_turn_r;

  assign p_fwd  = gain_p_fwd_r * err_fwd_r;
  assign d_fwd  = gain_d_fwd_r * derr_fwd_r;
  assign p_turn = gain_p_turn_r * err_turn_r;
  assign d_turn = gain_d_turn_r * derr_turn_r;

  always_ff @(posedge clk) begin
    if (s3_free) begin
      pd_fwd_r  <= p_fwd + d_fwd;
      pd_turn_r <= p_turn + d_turn;
    end
  end

  // mix, clip and map to direction and compare values
  logic signed [16:0] pd_fwd_s, pd_turn_s, left_sum, right_sum, left_cmd, right_cmd;
  logic signed [16:0] left_cmp_s, right_cmp_s;
  out_item_t          out_nxt;
  out_item_t          out_r;

  assign pd_fwd_s  = {pd_fwd_r[15], pd_fwd_r};
  assign pd_turn_s = {pd_turn_r[15], pd_turn_r};
  assign left_sum  = pd_fwd_s - pd_turn_s;
  assign right_sum = pd_fwd_s + pd_turn_s;

  always_comb begin
    priority if (left_sum > LIM_S)   left_cmd = LIM_S;
    else if (left_sum < -LIM_S)      left_cmd = -LIM_S;
    else                             left_cmd = left_sum;
    priority if (right_sum > LIM_S)  right_cmd = LIM_S;
    else if (right_sum < -LIM_S)     right_cmd = -LIM_S;
    else                             right_cmd = right_sum;
  end

  assign left_cmp_s  = (left_cmd < 0) ? PERIOD_S + left_cmd : left_cmd;
  assign right_cmp_s = (right_cmd > 0) ? PERIOD_S - right_cmd : -right_cmd;

  always_comb begin
    out_nxt = '0;
    if (drive_enable_r) begin
      out_nxt.left_dir      = (left_cmd < 0);
      out_nxt.left_compare  = left_cmp_s[9:0];
      out_nxt.right_dir     = (right_cmd > 0);
      out_nxt.right_compare = right_cmp_s[9:0];
      out_nxt.drive_written = 1'b1;
    end else begin
      out_nxt.drive_written = !hold_when_off_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

[hdl/ddpd_checker.sv]
`timescale 1ns / 1ps
// ddpd_checker: port level checks for the pd controller top level
// depends on ddpd_pkg and is bound to differential_drive_pd_controller_core

module ddpd_checker
  import ddpd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input out_item_t             out_data
);

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input side only backs up when a result is waiting at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with a free pipeline");

  // an item that leaves the pwm alone carries zeroed drive fields
  a_hold_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.drive_written |->
      !out_data.left_dir && !out_data.right_dir &&
      out_data.left_compare == 10'd0 && out_data.right_compare == 10'd0)
    else $error("held item carries drive values");

endmodule

bind differential_drive_pd_controller_core ddpd_checker u_ddpd_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for differential_drive_pd_controller_core
// a scoreboard class predicts each control tick; needs ddpd_pkg and the core

module tb;
  import ddpd_pkg::*;

  localparam int PERIOD      = 1000;
  localparam int LATENCY     = 4;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_ITEMS = 65;
  localparam int LONG_HOLD   = 150;
  // indexes that decode to no register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  // scoreboard: own copy of gains, encoder and error state, queue of commands
  class drive_cmd_tracker;
    logic signed [15:0] kp_fwd, kp_turn, kd_fwd, kd_turn;
    logic               drive_on, hold_off;
    logic [15:0]        prev_l, prev_r, perr_fwd, perr_turn, last_fwd, last_turn;
    out_item_t          pending_cmds[$];
    int                 errors;
    int                 checked;

    function new();
      kp_fwd    = 16'sd1;
      kp_turn   = 16'sd1;
      kd_fwd    = 16'sd1;
      kd_turn   = 16'sd1;
      drive_on  = 1'b0;
      hold_off  = 1'b0;
      prev_l    = '0;
      prev_r    = '0;
      perr_fwd  = '0;
      perr_turn = '0;
      last_fwd  = '0;
      last_turn = '0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_GAIN_P_FORWARD: kp_fwd   = value;
        CFG_GAIN_P_TURN:    kp_turn  = value;
        CFG_GAIN_D_FORWARD: kd_fwd   = value;
        CFG_GAIN_D_TURN:    kd_turn  = value;
        CFG_DRIVE_ENABLE:   drive_on = value[0];
        CFG_HOLD_WHEN_OFF:  hold_off = value[0];
        default: ;
      endcase
    endfunction

    // exact pd sum, then keep the low 16 bits as a signed value
    function logic signed [15:0] pd_term(logic signed [15:0] kp, logic signed [15:0] kd,
                                         logic [15:0] err, logic [15:0] last);
      longint e, dlt, t;
      e   = $signed(err);
      dlt = e - longint'($signed(last));
      t   = longint'(kp) * e + longint'(kd) * dlt;
      return t[15:0];
    endfunction

    function int clip_cmd(int v);
      if (v > PERIOD - 1) return PERIOD - 1;
      if (v < -(PERIOD - 1)) return -(PERIOD - 1);
      return v;
    endfunction

    // one accepted tick: update state and queue the expected command
    function void take_tick(in_item_t it);
      logic [15:0] nl, sl, sr, fb_fwd, fb_turn;
      int          pf, pt, lcmd, rcmd, lcmp, rcmp;
      out_item_t   r;
      nl        = 16'd0 - it.left_count;
      sl        = nl - prev_l;
      sr        = it.right_count - prev_r;
      fb_fwd    = sl + sr;
      fb_turn   = sr - sl;
      prev_l    = nl;
      prev_r    = it.right_count;
      perr_fwd  = perr_fwd + $unsigned(it.target_forward) - fb_fwd;
      perr_turn = perr_turn + $unsigned(it.target_turn) - fb_turn;
      pf        = pd_term(kp_fwd, kd_fwd, perr_fwd, last_fwd);
      pt        = pd_term(kp_turn, kd_turn, perr_turn, last_turn);
      last_fwd  = perr_fwd;
      last_turn = perr_turn;
      lcmd      = clip_cmd(pf - pt);
      rcmd      = clip_cmd(pf + pt);
      r = '0;
      if (!drive_on) begin
        r.drive_written = !hold_off;
      end else begin
        lcmp            = (lcmd < 0) ? PERIOD + lcmd : lcmd;
        rcmp            = (rcmd > 0) ? PERIOD - rcmd : -rcmd;
        r.left_dir      = (lcmd < 0);
        r.left_compare  = lcmp[9:0];
        r.right_dir     = (rcmd > 0);
        r.right_compare = rcmp[9:0];
        r.drive_written = 1'b1;
      end
      pending_cmds.push_back(r);
    endfunction

    function void cmp_field(string name, logic [9:0] exp_v, logic [9:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_cmd(out_item_t got);
      out_item_t exp_cmd;
      if (pending_cmds.size() == 0) begin
        $error("result item with no tick outstanding: %h", got);
        errors++;
        return;
      end
      exp_cmd = pending_cmds.pop_front();
      checked++;
      cmp_field("left_dir", 10'(exp_cmd.left_dir), 10'(got.left_dir));
      cmp_field("left_compare", exp_cmd.left_compare, got.left_compare);
      cmp_field("right_dir", 10'(exp_cmd.right_dir), 10'(got.right_dir));
      cmp_field("right_compare", exp_cmd.right_compare, got.right_compare);
      cmp_field("drive_written", 10'(exp_cmd.drive_written), 10'(got.drive_written));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic [15:0]           enc_l, enc_r;

  drive_cmd_tracker tracker = new();

  differential_drive_pd_controller_core #(
    .PWM_PERIOD(PERIOD)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock, 8 ns period
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watch all three channels at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (out_valid && !out_stall) tracker.check_cmd(out_data);
      if (in_valid && !in_stall) tracker.take_tick(in_data);
    end
  end

  // receiver stall pattern, with one long hold-off once traffic is under way
  initial begin
    int run_len, kind;
    bit long_done;
    out_stall = 1'b0;
    long_done = 1'b0;
    forever begin
      if (!long_done && tracker.checked >= 300) begin
        long_done = 1'b1;
        repeat (LONG_HOLD) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end
      run_len = $urandom_range(1, 40);
      kind    = $urandom_range(0, 4);
      for (int i = 0; i < run_len; i++) begin
        @(posedge clk);
        case (kind)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          3: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= i[0];
        endcase
      end
    end
  end

  function automatic in_item_t tick_item(int l, int r, int f, int t);
    in_item_t it;
    it.left_count     = l[15:0];
    it.right_count    = r[15:0];
    it.target_forward = f[15:0];
    it.target_turn    = t[15:0];
    return it;
  endfunction

  function automatic int small_gain(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // offer one item and hold it until taken
  task automatic send_tick(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait for every outstanding command
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_cmds.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_drive(int kpf, int kpt, int kdf, int kdt, bit drive_on, bit hold_off);
    write_cfg(CFG_GAIN_P_FORWARD, kpf);
    write_cfg(CFG_GAIN_P_TURN, kpt);
    write_cfg(CFG_GAIN_D_FORWARD, kdf);
    write_cfg(CFG_GAIN_D_TURN, kdt);
    write_cfg(CFG_DRIVE_ENABLE, int'(drive_on));
    write_cfg(CFG_HOLD_WHEN_OFF, int'(hold_off));
  endtask

  // mostly smooth encoder motion with modest targets, some fully random items
  task automatic run_random(int n, int span, bit gaps, bit pause_mid);
    int       burst, gap, delta;
    in_item_t it;
    burst = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) drain();
      if ($urandom_range(0, 3) == 0) begin
        it = {$urandom, $urandom};
      end else begin
        delta = int'($urandom_range(0, 2 * span)) - span;
        enc_l = enc_l + delta[15:0];
        delta = int'($urandom_range(0, 2 * span)) - span;
        enc_r = enc_r + delta[15:0];
        it = tick_item(enc_l, enc_r, int'($urandom_range(0, 4 * span)) - 2 * span,
                       int'($urandom_range(0, 2 * span)) - span);
      end
      send_tick(it);
      burst--;
      if (gaps && burst == 0) begin
        gap = $urandom_range(0, 10);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 24);
      end
    end
  endtask

  // main sequence
  initial begin
    int span;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    enc_l     = '0;
    enc_r     = '0;
    rst_n     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // drive off after reset: zero commands, state still tracks
    send_tick(tick_item(16'h0010, 16'h0020, 100, -50));
    send_tick(tick_item(16'hfff0, 16'h0040, -7, 9));
    send_tick(tick_item(16'hffe0, 16'h0060, 0, 0));
    drain();

    // modest gains, drive on; spare indexes must not touch anything
    set_drive(2, 1, 1, 3, 1'b1, 1'b0);
    write_cfg(CFG_SPARE_6, -1);
    write_cfg(CFG_SPARE_7, 0);
    send_tick(tick_item(0, 0, 0, 0));
    send_tick(tick_item(16'hffff, 0, 0, 0));
    send_tick(tick_item(0, 16'hffff, 0, 0));
    send_tick(tick_item(16'h8000, 16'h7fff, 32767, -32768));
    send_tick(tick_item(16'h7fff, 16'h8000, -32768, 32767));
    send_tick(tick_item(16'h7fff, 16'h8000, 0, 0));
    send_tick(tick_item(16'h7ff0, 16'h8010, 5, 3));
    send_tick(tick_item(16'h7fe8, 16'h8018, 8, 0));
    send_tick(tick_item(16'h7fe8, 16'h8018, 0, 0));
    send_tick(tick_item(16'h7fe8, 16'h8018, -200, 300));
    send_tick(tick_item(0, 0, 0, 0));
    drain();

    // extreme gains: truncation of the pd sum and clipping both ways
    set_drive(32767, -32768, -32768, 32767, 1'b1, 1'b0);
    send_tick(tick_item(16'h0003, 16'hfffd, 1, -1));
    send_tick(tick_item(16'h1234, 16'hedcb, 32767, 32767));
    send_tick(tick_item(16'hffff, 16'hffff, -32768, -32768));
    send_tick(tick_item(16'h0001, 16'h0001, 0, 0));
    drain();

    // drive off with hold, then drive off without hold
    set_drive(3, -2, 1, 0, 1'b0, 1'b1);
    send_tick(tick_item(16'h0100, 16'h0200, 40, -40));
    send_tick(tick_item(16'h0110, 16'h0220, 40, -40));
    drain();
    write_cfg(CFG_HOLD_WHEN_OFF, 0);
    send_tick(tick_item(16'h0120, 16'h0240, 40, -40));
    drain();

    // random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_drive(small_gain(4), small_gain(4), small_gain(4), small_gain(4), 1'b1, 1'b0);
        1: set_drive(32767, -32768, 32767, -32768, 1'b1, 1'b0);
        2: set_drive($urandom, $urandom, $urandom, $urandom, 1'b0, 1'b1);
        3: set_drive(0, 0, 0, 0, 1'b1, 1'b0);
        4: set_drive($urandom, $urandom, $urandom, $urandom, 1'b1,
                     1'($urandom_range(0, 1)));
        5: set_drive(-32768, 32767, -32768, 32767, 1'b0, 1'b0);
        default: set_drive(small_gain(16), small_gain(16), small_gain(16), small_gain(16),
                           1'b1, 1'($urandom_range(0, 1)));
      endcase
      span = (p % 2) ? 40 : 6;
      run_random(PHASE_ITEMS, span, p != 3, p == 6);
      drain();
    end

    if (tracker.errors == 0 && tracker.pending_cmds.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
